// ----- hw/rtl/kmc_pkg.sv -----
// ----------------------------------------------------------------------------
// K-mer match counter package
// Shared constants, codes and types for the front, queue and back modules.
// ----------------------------------------------------------------------------
package kmc_pkg;

   // Table size must be a power of two; the home slot is a bit field of the hash.
   localparam int TABLE_ENTRIES = 16384;
   localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
   localparam int MAX_K         = 32;
   localparam int KEY_W         = 64;
   localparam int COUNT_W       = 32;
   localparam int LEN_W         = 6;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_W-1:0] KMER_LEN_RESET = 6'd21;
   localparam logic [63:0]      HASH_MULT      = 64'h9E3779B97F4A7C15;

   // Input action codes.
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_SCAN  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_MISS = 2'd3;

   // Classified operation handed from the front to the back.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    key;
      logic [SLOT_W-1:0]   slot;
   } job_type;

   // Queue status seen by the front.
   typedef struct packed {
      logic full;
   } queue_status_type;

   // Back status seen by the front.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } slot_entry_type;

endpackage

// ----- hw/rtl/kmc_front.sv -----
// ----------------------------------------------------------------------------
// K-mer match counter front end
// Accepts items, keeps the read window, builds the lookup key and its home
// slot, and pushes a classified job into the queue.
// ----------------------------------------------------------------------------
module kmc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [kmc_pkg::LEN_W-1:0]           csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [kmc_pkg::KEY_W-1:0]           req_kmer_code,
   input  logic [2:0]                          req_base,
   input  logic                                req_read_start,
   input  kmc_pkg::back_status_type            back_status,
   input  kmc_pkg::queue_status_type           queue_status,
   output logic                                push,
   output kmc_pkg::job_type                    push_job
);

   logic [kmc_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [kmc_pkg::KEY_W-1:0]  win_ff, win_in;
   logic [kmc_pkg::LEN_W-1:0]  run_ff, run_in;
   logic                       s1_valid_ff, s1_valid_in;
   kmc_pkg::op_type            s1_op_ff, s1_op_in;
   logic [kmc_pkg::KEY_W-1:0]  s1_key_ff, s1_key_in;
   logic [63:0]                p_ll_ff, p_ll_in;
   logic [kmc_pkg::SLOT_W-1:0] p_lh_ff, p_lh_in, p_hl_ff, p_hl_in;

   logic                       req_fire;
   logic [kmc_pkg::LEN_W-1:0]  k_eff;
   logic [kmc_pkg::KEY_W-1:0]  len_mask;
   logic [kmc_pkg::KEY_W-1:0]  win0;
   logic [kmc_pkg::LEN_W-1:0]  run0, run1;

   assign req_stall = back_status.clearing || (s1_valid_ff && queue_status.full);
   assign req_fire  = req_valid && !req_stall;
   assign push      = s1_valid_ff && !queue_status.full;

   // Effective k-mer length and its key mask.
   always_comb begin
      if (len_ff == '0) begin
         k_eff = kmc_pkg::LEN_W'(1);
      end else if (len_ff > kmc_pkg::LEN_W'(kmc_pkg::MAX_K)) begin
         k_eff = kmc_pkg::LEN_W'(kmc_pkg::MAX_K);
      end else begin
         k_eff = len_ff;
      end
      if (k_eff >= kmc_pkg::LEN_W'(32)) begin
         len_mask = '1;
      end else begin
         len_mask = (64'd1 << {k_eff, 1'b0}) - 64'd1;
      end
   end

   // Classify the item and update the read window on a scan.
   always_comb begin
      win_in    = win_ff;
      run_in    = run_ff;
      s1_op_in  = kmc_pkg::OP_NONE;
      s1_key_in = req_kmer_code & len_mask;
      win0      = req_read_start ? '0 : win_ff;
      run0      = req_read_start ? '0 : run_ff;
      run1      = (run0 > k_eff) ? k_eff : run0;
      if (run1 < k_eff) begin
         run1 = run1 + kmc_pkg::LEN_W'(1);
      end
      unique case (req_action)
         kmc_pkg::ACT_LOAD: begin
            s1_op_in = kmc_pkg::OP_LOAD;
         end
         kmc_pkg::ACT_QUERY: begin
            s1_op_in = kmc_pkg::OP_QUERY;
         end
         kmc_pkg::ACT_SCAN: begin
            if (req_base > 3'd3) begin
               win_in = '0;
               run_in = '0;
            end else begin
               win_in    = ((win0 << 2) | kmc_pkg::KEY_W'(req_base)) & len_mask;
               run_in    = run1;
               s1_key_in = win_in;
               if (run1 >= k_eff) begin
                  s1_op_in = kmc_pkg::OP_SCAN;
               end
            end
         end
         default: begin
            s1_op_in = kmc_pkg::OP_NONE;
         end
      endcase
   end

   // Partial products of the hash; the cross products keep only the home-slot bits.
   always_comb begin
      p_ll_in = s1_key_in[31:0] * kmc_pkg::HASH_MULT[31:0];
      p_lh_in = kmc_pkg::SLOT_W'(s1_key_in[kmc_pkg::SLOT_W-1:0]
                * kmc_pkg::HASH_MULT[32 +: kmc_pkg::SLOT_W]);
      p_hl_in = kmc_pkg::SLOT_W'(s1_key_in[32 +: kmc_pkg::SLOT_W]
                * kmc_pkg::HASH_MULT[kmc_pkg::SLOT_W-1:0]);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
      len_in = csr_wr_en ? csr_wr_data : len_ff;
   end

   // Home slot is the sum of the partial products at bit 32.
   always_comb begin
      push_job.op   = s1_op_ff;
      push_job.key  = s1_key_ff;
      push_job.slot = p_ll_ff[32 +: kmc_pkg::SLOT_W] + p_lh_ff + p_hl_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= kmc_pkg::KMER_LEN_RESET;
         win_ff      <= '0;
         run_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         s1_valid_ff <= s1_valid_in;
         if (req_fire && (req_action == kmc_pkg::ACT_SCAN)) begin
            win_ff <= win_in;
            run_ff <= run_in;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= s1_op_in;
         s1_key_ff <= s1_key_in;
         p_ll_ff   <= p_ll_in;
         p_lh_ff   <= p_lh_in;
         p_hl_ff   <= p_hl_in;
      end
   end

endmodule

// ----- hw/rtl/kmc_queue.sv -----
// ----------------------------------------------------------------------------
// K-mer match counter job queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module kmc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kmc_pkg::job_type          push_job,
   output kmc_pkg::queue_status_type queue_status,
   input  logic                      pop,
   output logic                      empty,
   output kmc_pkg::job_type          head_job
);

   kmc_pkg::job_type             slots_ff [kmc_pkg::QUEUE_DEPTH];
   logic [kmc_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [kmc_pkg::QPTR_W:0]     fill_ff, fill_in;

   assign empty             = (fill_ff == '0);
   assign queue_status.full = (fill_ff == (kmc_pkg::QPTR_W+1)'(kmc_pkg::QUEUE_DEPTH));
   assign head_job          = slots_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (kmc_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (kmc_pkg::QPTR_W+1)'(1);
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + kmc_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + kmc_pkg::QPTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- hw/rtl/kmc_back.sv -----
// ----------------------------------------------------------------------------
// K-mer match counter back end
// Walks the hash table by linear probing, inserts, counts and reads k-mers,
// and holds the result register. Clears the table after reset.
// ----------------------------------------------------------------------------
module kmc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            empty,
   input  kmc_pkg::job_type                head_job,
   output logic                            pop,
   output kmc_pkg::back_status_type        back_status,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [kmc_pkg::COUNT_W-1:0]     rsp_count
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } state_type;

   kmc_pkg::slot_entry_type table_mem [kmc_pkg::TABLE_ENTRIES];
   kmc_pkg::slot_entry_type rd_q_ff;

   state_type                   state_ff, state_in;
   logic [kmc_pkg::SLOT_W-1:0]  clr_ff, clr_in;
   kmc_pkg::op_type             op_ff, op_in;
   logic [kmc_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kmc_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic [kmc_pkg::SLOT_W-1:0]  probe_ff, probe_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [kmc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        wr_en;
   logic [kmc_pkg::SLOT_W-1:0]  wr_addr;
   kmc_pkg::slot_entry_type     wr_data;
   logic                        out_free;
   logic                        hit;
   logic [kmc_pkg::COUNT_W-1:0] cnt_inc;

   assign out_free             = !rsp_valid_ff || !rsp_stall;
   assign back_status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_count            = rsp_count_ff;
   assign hit                  = rd_q_ff.used && (rd_q_ff.key == key_ff);
   assign cnt_inc              = (&rd_q_ff.count) ? rd_q_ff.count
                                 : rd_q_ff.count + kmc_pkg::COUNT_W'(1);

   // Probe sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = rd_q_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + kmc_pkg::SLOT_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty && out_free) begin
               pop      = 1'b1;
               op_in    = head_job.op;
               key_in   = head_job.key;
               slot_in  = head_job.slot;
               probe_in = '0;
               if (head_job.op == kmc_pkg::OP_NONE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = kmc_pkg::STATUS_MISS;
                  rsp_count_in  = '0;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = rd_q_ff.count;
               if (op_ff == kmc_pkg::OP_LOAD) begin
                  rsp_status_in = kmc_pkg::STATUS_DUP;
               end else begin
                  rsp_status_in = kmc_pkg::STATUS_OK;
               end
               if (op_ff == kmc_pkg::OP_SCAN) begin
                  wr_en         = 1'b1;
                  wr_data.count = cnt_inc;
                  rsp_count_in  = cnt_inc;
               end
            end else if (!rd_q_ff.used) begin
               // Empty slot ends the probe: insert on load, miss otherwise.
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = '0;
               if (op_ff == kmc_pkg::OP_LOAD) begin
                  wr_en         = 1'b1;
                  wr_data.used  = 1'b1;
                  wr_data.key   = key_ff;
                  wr_data.count = '0;
                  rsp_status_in = kmc_pkg::STATUS_OK;
               end else begin
                  rsp_status_in = kmc_pkg::STATUS_MISS;
               end
            end else if (&probe_ff) begin
               // Every slot was visited without a match or a free slot.
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_count_in = '0;
               if (op_ff == kmc_pkg::OP_LOAD) begin
                  rsp_status_in = kmc_pkg::STATUS_FULL;
               end else begin
                  rsp_status_in = kmc_pkg::STATUS_MISS;
               end
            end else begin
               state_in = ST_READ;
               slot_in  = slot_ff + kmc_pkg::SLOT_W'(1);
               probe_in = probe_ff + kmc_pkg::SLOT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= table_mem[slot_ff];
   end

endmodule

// ----- hw/rtl/kmer_match_counter_unit.sv -----
// ----------------------------------------------------------------------------
// K-mer match counter unit
// Counts occurrences of loaded k-mers in scanned reads using a linearly
// probed hash table; loads insert, scans count, queries read back.
// ----------------------------------------------------------------------------
// An item is registered in the front, queued, then probed by the back end, one
// slot read and check after another. The back end serves one item at a time
// via its single table read port; the front takes items until the queue fills.
// Reset is synchronous; a clearing pass then runs over all 16384 slots and
// no item is accepted during it. The k-mer length register resets to 21.
module kmer_match_counter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [kmc_pkg::LEN_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [kmc_pkg::KEY_W-1:0]       req_kmer_code,
   input  logic [2:0]                      req_base,
   input  logic                            req_read_start,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [kmc_pkg::COUNT_W-1:0]     rsp_count
);

   kmc_pkg::back_status_type  back_status;
   kmc_pkg::queue_status_type queue_status;
   kmc_pkg::job_type          push_job, head_job;
   logic                      push, pop, empty;

   // Front end: window, classification and hashing.
   kmc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_kmer_code  (req_kmer_code),
      .req_base       (req_base),
      .req_read_start (req_read_start),
      .back_status    (back_status),
      .queue_status   (queue_status),
      .push           (push),
      .push_job       (push_job)
   );

   // Job queue between the two halves.
   kmc_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .queue_status (queue_status),
      .pop          (pop),
      .empty        (empty),
      .head_job     (head_job)
   );

   // Back end: table probing and result register.
   kmc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head_job    (head_job),
      .pop         (pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

endmodule
